>>> hw/rtl/bam_pkg.sv
// Shared types, codes and helpers of the bitmap allocation map.
// Used by the channel interfaces and by the top module of the block.
package bam_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int REACH_BYTES   = 64;  // bytes a 9-bit bit index can address
  localparam int IDX_W         = 9;
  localparam int BYTE_IDX_W    = 6;
  localparam int POS_W         = 3;
  localparam int COUNT_W       = 7;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_FIND  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_FINISH
  } state_t;

  // Position of the least significant zero bit; only called on a byte that has one.
  function automatic logic [POS_W-1:0] first_zero(input logic [BITS_PER_BYTE-1:0] b);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
      if (!b[i]) begin
        pos = POS_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

>>> hw/rtl/bam_req_if.sv
// Request channel of the bitmap allocation map: valid/ready plus one request beat.
// Depends on bam_pkg for the opcode type and field widths.
interface bam_req_if;
  logic                           valid;
  logic                           ready;
  bam_pkg::opcode_t               opcode;
  logic [bam_pkg::IDX_W-1:0]      bit_index;

  modport source (output valid, output opcode, output bit_index, input ready);
  modport sink   (input valid, input opcode, input bit_index, output ready);
endinterface

>>> hw/rtl/bam_rsp_if.sv
// Response channel of the bitmap allocation map: valid/ready plus one result beat.
// Depends on bam_pkg for the status type and field widths.
interface bam_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           bit_value;
  logic [bam_pkg::IDX_W-1:0]      found_index;
  bam_pkg::status_t               status;

  modport source (output valid, output bit_value, output found_index, output status,
                  input ready);
  modport sink   (input valid, input bit_value, input found_index, input status,
                  output ready);
endinterface

>>> hw/rtl/bitmap_allocation_map_top.sv
// Bitmap allocation map: a bit map of up to 64 bytes held in one synchronous RAM.
// After reset the block runs a clearing pass, one map byte per cycle, and accepts
// no request until it ends. Requests are handled one at a time: set, clear and read
// pass through a memory read, a modify and write back, and a result step, and an
// out-of-range index skips the modify step. A find reads one map byte per cycle
// through the single RAM read port and examines at most the active byte count.
// The result sits in an output register, so a new request is accepted while the
// last result still waits on the response channel. The user must write bytes_in_use
// only while the block is idle; the block itself does not enforce this. Its value is
// saturated to the map size where it is used.
module bitmap_allocation_map_top #(
  parameter int MAP_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bam_pkg::COUNT_W-1:0]     cfg_data,
  bam_req_if.sink                         req,
  bam_rsp_if.source                       rsp
);

  localparam int DEPTH = (MAP_BYTES < bam_pkg::REACH_BYTES) ? MAP_BYTES
                                                            : bam_pkg::REACH_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = bam_pkg::BITS_PER_BYTE;

  bam_pkg::state_t                 state, state_next;
  logic [bam_pkg::COUNT_W-1:0]     bytes_in_use, bytes_in_use_next;
  logic [AW-1:0]                   ptr, ptr_next;
  logic                            out_valid, out_valid_next;

  bam_pkg::opcode_t                op, op_next;
  logic [bam_pkg::BYTE_IDX_W-1:0]  byte_idx, byte_idx_next;
  logic [bam_pkg::POS_W-1:0]       bit_pos, bit_pos_next;
  logic                            res_bit, res_bit_next;
  logic [bam_pkg::IDX_W-1:0]       res_found, res_found_next;
  bam_pkg::status_t                res_status, res_status_next;
  logic                            out_bit, out_bit_next;
  logic [bam_pkg::IDX_W-1:0]       out_found, out_found_next;
  bam_pkg::status_t                out_status, out_status_next;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [BW-1:0]                   ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [BW-1:0]                   ram_rdata;

  logic [bam_pkg::COUNT_W-1:0]     active;
  logic [bam_pkg::BYTE_IDX_W-1:0]  req_byte;
  logic [BW-1:0]                   mask;

  bam_ram #(
    .WIDTH (BW),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign active   = (bytes_in_use > bam_pkg::COUNT_W'(DEPTH)) ? bam_pkg::COUNT_W'(DEPTH)
                                                               : bytes_in_use;
  assign req_byte = req.bit_index[bam_pkg::IDX_W-1:bam_pkg::POS_W];
  assign mask     = BW'(1) << bit_pos;

  assign req.ready       = (state == bam_pkg::S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.bit_value   = out_bit;
  assign rsp.found_index = out_found;
  assign rsp.status      = out_status;

  always_comb begin
    state_next        = state;
    bytes_in_use_next = bytes_in_use;
    ptr_next          = ptr;
    out_valid_next    = out_valid;
    op_next           = op;
    byte_idx_next     = byte_idx;
    bit_pos_next      = bit_pos;
    res_bit_next      = res_bit;
    res_found_next    = res_found;
    res_status_next   = res_status;
    out_bit_next      = out_bit;
    out_found_next    = out_found;
    out_status_next   = out_status;
    ram_we            = 1'b0;
    ram_waddr         = ptr;
    ram_wdata         = '0;
    ram_raddr         = ptr;

    if (cfg_write) begin
      bytes_in_use_next = cfg_data;
    end
    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      bam_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        if (ptr == AW'(DEPTH - 1)) begin
          ptr_next   = '0;
          state_next = bam_pkg::S_IDLE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end

      bam_pkg::S_IDLE: begin
        if (req.valid) begin
          op_next         = req.opcode;
          byte_idx_next   = req_byte;
          bit_pos_next    = req.bit_index[bam_pkg::POS_W-1:0];
          res_bit_next    = 1'b0;
          res_found_next  = '0;
          res_status_next = bam_pkg::ST_OK;
          if (req.opcode == bam_pkg::OP_FIND) begin
            ptr_next  = '0;
            ram_raddr = '0;
            if (active == '0) begin
              res_status_next = bam_pkg::ST_FULL;
              state_next      = bam_pkg::S_FINISH;
            end else begin
              state_next = bam_pkg::S_SCAN;
            end
          end else begin
            ram_raddr = req_byte[AW-1:0];
            if ({1'b0, req_byte} >= active) begin
              res_status_next = bam_pkg::ST_RANGE;
              state_next      = bam_pkg::S_FINISH;
            end else begin
              state_next = bam_pkg::S_RMW;
            end
          end
        end
      end

      bam_pkg::S_RMW: begin
        ram_waddr = byte_idx[AW-1:0];
        case (op)
          bam_pkg::OP_SET: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | mask;
          end
          bam_pkg::OP_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~mask;
          end
          bam_pkg::OP_READ: begin
            res_bit_next = ram_rdata[bit_pos];
          end
          default: begin
          end
        endcase
        state_next = bam_pkg::S_FINISH;
      end

      bam_pkg::S_SCAN: begin
        // The read data belongs to the byte at ptr; the next byte is fetched meanwhile.
        if (ram_rdata != '1) begin
          res_found_next = {bam_pkg::BYTE_IDX_W'(ptr), bam_pkg::first_zero(ram_rdata)};
          state_next     = bam_pkg::S_FINISH;
        end else if (bam_pkg::COUNT_W'(ptr) + bam_pkg::COUNT_W'(1) >= active) begin
          res_status_next = bam_pkg::ST_FULL;
          state_next      = bam_pkg::S_FINISH;
        end else begin
          ptr_next  = ptr + AW'(1);
          ram_raddr = ptr + AW'(1);
        end
      end

      bam_pkg::S_FINISH: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_bit_next    = res_bit;
          out_found_next  = res_found;
          out_status_next = res_status;
          state_next      = bam_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bam_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bam_pkg::S_CLEAR;
      bytes_in_use <= bam_pkg::COUNT_W'(64);
      ptr          <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      bytes_in_use <= bytes_in_use_next;
      ptr          <= ptr_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    byte_idx   <= byte_idx_next;
    bit_pos    <= bit_pos_next;
    res_bit    <= res_bit_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
    out_bit    <= out_bit_next;
    out_found  <= out_found_next;
    out_status <= out_status_next;
  end

endmodule

>>> hw/rtl/bam_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module bam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> verif/tb_bitmap_allocation_map_top.sv
// Self-checking testbench for bitmap_allocation_map_top: set, clear, read and find-first-clear
// requests checked against an in-bench prediction of the bit map, under several idle patterns.
// Depends on bam_pkg, bam_req_if, bam_rsp_if and the bitmap_allocation_map_top RTL.
module tb_bitmap_allocation_map_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bam_pkg::*;

  localparam int MAP_BYTES   = 64;
  localparam int CFG_SETTLE  = MAP_BYTES + 8;   // covers the clearing pass and the longest find
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    opcode_t              opcode;
    logic [IDX_W-1:0]     bit_index;
  } map_request_t;

  typedef struct packed {
    logic                 bit_value;
    logic [IDX_W-1:0]     found_index;
    status_t              status;
  } map_reply_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [COUNT_W-1:0] cfg_data;

  bam_req_if req_ch();
  bam_rsp_if rsp_ch();

  bitmap_allocation_map_top #(
    .MAP_BYTES (MAP_BYTES)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Predicted state of the block.
  logic [BITS_PER_BYTE-1:0] shadow_map [MAP_BYTES];
  logic [COUNT_W-1:0]       shadow_bytes_in_use;

  map_request_t request_queue [$];
  map_reply_t   predicted_replies [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_token;
  int hold_seen;
  int hold_left;
  int error_count;
  int cycle_count;
  map_request_t next_request;

  always #2 clk = ~clk;

  function automatic int active_bytes();
    int n;
    n = shadow_bytes_in_use;
    if (n > MAP_BYTES) n = MAP_BYTES;
    if (n > REACH_BYTES) n = REACH_BYTES;
    return n;
  endfunction

  // Applies one request to the shadow map and returns the reply it should produce.
  function automatic map_reply_t apply_map_request(opcode_t op, logic [IDX_W-1:0] idx);
    map_reply_t r;
    int n;
    int row;
    logic hit;
    n = active_bytes();
    row = idx / BITS_PER_BYTE;
    hit = 1'b0;
    r.bit_value = 1'b0;
    r.found_index = '0;
    r.status = ST_OK;
    if (op == OP_FIND) begin
      for (int i = 0; i < n && !hit; i++) begin
        for (int j = 0; j < BITS_PER_BYTE; j++) begin
          if (!hit && !shadow_map[i][j]) begin
            r.found_index = IDX_W'(i * BITS_PER_BYTE + j);
            hit = 1'b1;
          end
        end
      end
      if (!hit) r.status = ST_FULL;
    end else if (row >= n) begin
      r.status = ST_RANGE;
    end else if (op == OP_SET) begin
      shadow_map[row][idx % BITS_PER_BYTE] = 1'b1;
    end else if (op == OP_CLEAR) begin
      shadow_map[row][idx % BITS_PER_BYTE] = 1'b0;
    end else begin
      r.bit_value = shadow_map[row][idx % BITS_PER_BYTE];
    end
    return r;
  endfunction

  // Most indexes land inside the active bytes so that the map fills and empties.
  function automatic map_request_t random_request();
    map_request_t q;
    int pick;
    int n;
    n = active_bytes();
    pick = $urandom_range(99);
    if (pick < 35) q.opcode = OP_SET;
    else if (pick < 60) q.opcode = OP_CLEAR;
    else if (pick < 75) q.opcode = OP_READ;
    else q.opcode = OP_FIND;
    if (n > 0 && $urandom_range(9) < 8) q.bit_index = IDX_W'($urandom_range(n * BITS_PER_BYTE - 1));
    else q.bit_index = IDX_W'($urandom_range(511));
    return q;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predicted_replies.push_back(apply_map_request(req_ch.opcode, req_ch.bit_index));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_request = request_queue.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.opcode <= next_request.opcode;
          req_ch.bit_index <= next_request.bit_index;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Reply ready, with an occasional long hold-off requested by the stimulus.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Reply monitor.
  always @(posedge clk) begin
    map_reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (predicted_replies.size() == 0) begin
        $error("reply beat with no request outstanding");
        error_count++;
      end else begin
        want = predicted_replies.pop_front();
        if (rsp_ch.bit_value !== want.bit_value) begin
          $error("bit_value: expected %0d, actual %0d", want.bit_value, rsp_ch.bit_value);
          error_count++;
        end
        if (rsp_ch.found_index !== want.found_index) begin
          $error("found_index: expected %0d, actual %0d", want.found_index, rsp_ch.found_index);
          error_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bitmap_allocation_map_top test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() > 0 || req_ch.valid || predicted_replies.size() > 0);
  endtask

  task automatic write_bytes_in_use(input logic [COUNT_W-1:0] value);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    shadow_bytes_in_use = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_request(input opcode_t op, input int idx);
    map_request_t q;
    q.opcode = op;
    q.bit_index = IDX_W'(idx);
    request_queue.push_back(q);
  endtask

  task automatic set_idling(input int mode);
    @(negedge clk);
    send_idle_pct = (mode == 1) ? 83 : (mode == 3) ? 33 : 0;
    recv_stall_pct = (mode == 2) ? 83 : (mode == 3) ? 33 : 0;
  endtask

  task automatic random_phase(input logic [COUNT_W-1:0] cfg, input int mode, input int count,
                              input bit long_hold, input bit mid_pause);
    write_bytes_in_use(cfg);
    set_idling(mode);
    for (int i = 0; i < count; i++) begin
      request_queue.push_back(random_request());
      if (mid_pause && i == count / 2) begin
        wait_drained();
      end
    end
    if (long_hold) begin
      hold_token++;
    end
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_SET;
    req_ch.bit_index = '0;
    rsp_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_token = 0;
    hold_seen = 0;
    hold_left = 0;
    error_count = 0;
    cycle_count = 0;
    shadow_bytes_in_use = 7'd64;
    for (int i = 0; i < MAP_BYTES; i++) shadow_map[i] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: empty map, the highest bit position, read back after set and clear.
    repeat (CFG_SETTLE) @(posedge clk);
    @(negedge clk);
    queue_request(OP_FIND, 0);
    queue_request(OP_SET, 511);
    queue_request(OP_READ, 511);
    queue_request(OP_READ, 510);
    queue_request(OP_CLEAR, 511);
    queue_request(OP_READ, 511);
    wait_drained();

    // One active byte: fill it until find reports a full map, free one bit and find it, then out-of-range indexes.
    write_bytes_in_use(7'd1);
    @(negedge clk);
    for (int i = 0; i < BITS_PER_BYTE; i++) queue_request(OP_SET, i);
    queue_request(OP_FIND, 0);
    queue_request(OP_CLEAR, 3);
    queue_request(OP_FIND, 0);
    queue_request(OP_SET, 8);
    queue_request(OP_READ, 511);
    wait_drained();

    // No active byte at all.
    write_bytes_in_use(7'd0);
    @(negedge clk);
    queue_request(OP_FIND, 0);
    queue_request(OP_SET, 0);
    wait_drained();

    // A count above the map size saturates to the whole map.
    write_bytes_in_use(7'd127);
    @(negedge clk);
    queue_request(OP_SET, 505);
    queue_request(OP_READ, 505);
    wait_drained();

    random_phase(7'd64, 0, 250, 1'b0, 1'b0);
    random_phase(7'd1, 1, 250, 1'b0, 1'b0);
    random_phase(7'd4, 2, 250, 1'b0, 1'b0);
    random_phase(7'd127, 3, 250, 1'b0, 1'b0);
    random_phase(7'd2, 0, 250, 1'b1, 1'b0);
    random_phase(7'd12, 1, 250, 1'b0, 1'b1);
    random_phase(COUNT_W'($urandom_range(1, 64)), 2, 250, 1'b0, 1'b0);
    random_phase(7'd8, 3, 250, 1'b0, 1'b0);

    repeat (CFG_SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("bitmap_allocation_map_top test passed");
    end else begin
      $display("bitmap_allocation_map_top test failed");
    end
    $finish;
  end

endmodule
